@@ hdl/dewd_pkg.sv @@
// Shared types and constants of the detector event word deframer.
// Used by the front end, the job queue, the result back end and the top level.
`default_nettype none

package dewd_pkg;

   localparam logic [31:0] EV_HEADER   = 32'h1234_cccc;
   localparam logic [31:0] DET_HEADER  = 32'head_ebaba;
   localparam logic [31:0] CARD_HEADER = 32'hbadc_afe0;
   localparam logic [31:0] CARD_MASK   = 32'hffff_fff0;

   localparam int WORD_W      = 32;
   localparam int NUMB_W      = 4;
   localparam int BOARD_W     = 3;
   localparam int MAX_BOARDS  = 8;
   localparam int DET_W       = 4;
   localparam int CHAN_W      = 10;
   localparam int SMP_W       = 14;
   localparam int RSP_TDATA_W = 32;
   localparam int QUEUE_DEPTH = 4;
   localparam int PTR_W       = $clog2(QUEUE_DEPTH);

   typedef enum logic [1:0] {
      KIND_SAMPLE   = 2'd0,
      KIND_DONE     = 2'd1,
      KIND_TRUNC    = 2'd2,
      KIND_MISMATCH = 2'd3
   } kind_type;

   // work handed from the front end to the back end
   typedef enum logic [1:0] {
      OP_SINGLE     = 2'd0,  // one result of the given kind
      OP_SAMPLES    = 2'd1,  // payload word: two samples
      OP_TRUNC_DONE = 2'd2   // truncated, then event complete
   } op_type;

   typedef struct packed {
      op_type                op;
      kind_type              kind;
      logic                  first;  // first payload word of a board
      logic [BOARD_W-1:0]    board;
      logic [WORD_W-1:0]     word;
   } job_type;

endpackage

`default_nettype wire

@@ hdl/detector_event_word_deframer_unit.sv @@
// Top level of the detector event word deframer: front end, job queue,
// back end and the board count register. Depends on dewd_pkg and the dewd_* modules.
//
// Takes one 32-bit stream word per transaction on req_* and walks the event
// framing (event header, per-board detector header hunt, card header hunt,
// head skip, payload, two footers, tail skip). Each payload word gives two
// sample results, low half first; framing words give a result only on a
// header mismatch, a truncated event or a completed event. The front end
// takes one word per cycle while its four-entry job queue has room; the back
// end emits one result per cycle while rsp_tready allows, through a single
// output register, so a payload word needs two results from the back end and a
// framing word at most one. A result passes through the job queue and the output register.
// num_boards is written on csr_* and must only change while the block is idle.
`default_nettype none

module detector_event_word_deframer_unit
   import dewd_pkg::*;
#(
   parameter int CHANNELS_PER_CHIP  = 64,
   parameter int CHIPS_PER_DETECTOR = 10,
   parameter int ADC_COUNT          = 5,
   parameter int HEAD_SKIP_WORDS    = 11,
   parameter int TAIL_SKIP_WORDS    = 9
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   // input stream
   input  wire logic                    req_tvalid,
   output logic                         req_tready,
   input  wire logic [WORD_W-1:0]       req_tdata,   // [31:0] word
   // result stream
   output logic                         rsp_tvalid,
   input  wire logic                    rsp_tready,
   output logic [RSP_TDATA_W-1:0]       rsp_tdata,   // [3:0] detector, [13:4] channel,
                                                     // [27:14] sample, [31:28] zero
   output logic [1:0]                   rsp_tuser,   // [1:0] kind
   output logic                         rsp_tlast,   // last result of the word
   // board count register
   input  wire logic                    csr_valid,
   output logic                         csr_ready,
   input  wire logic [NUMB_W-1:0]       csr_data     // [3:0] num_boards
);

   localparam int PAYLOAD_WORDS = CHIPS_PER_DETECTOR * CHANNELS_PER_CHIP;

   logic [NUMB_W-1:0]  num_boards_ff;
   logic               accept;
   logic               push, full, pop, head_valid;
   job_type            push_job, head;

   // the register is always writable
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_boards_ff <= NUMB_W'(6);
      end else if (csr_valid && csr_ready) begin
         num_boards_ff <= csr_data;
      end
   end

   // take a word whenever the queue can hold whatever job it may post
   assign req_tready = !full;
   assign accept     = req_tvalid && req_tready;

   dewd_front #(
      .PAYLOAD_WORDS   (PAYLOAD_WORDS),
      .HEAD_SKIP_WORDS (HEAD_SKIP_WORDS),
      .TAIL_SKIP_WORDS (TAIL_SKIP_WORDS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .word       (req_tdata),
      .num_boards (num_boards_ff),
      .push       (push),
      .job        (push_job)
   );

   dewd_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .full       (full),
      .pop        (pop),
      .head       (head),
      .head_valid (head_valid)
   );

   dewd_back #(
      .CHANNELS_PER_CHIP (CHANNELS_PER_CHIP),
      .ADC_COUNT         (ADC_COUNT),
      .PAYLOAD_WORDS     (PAYLOAD_WORDS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .head_valid (head_valid),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // hold the result stream empty straight after reset
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // status results carry no detector, channel or sample
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser != KIND_SAMPLE) |-> (rsp_tdata == '0))
      else $error("status result with payload bits");

   // only samples and a truncation followed by completion leave a word open
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tlast) |-> (rsp_tuser == KIND_SAMPLE || rsp_tuser == KIND_TRUNC))
      else $error("unexpected open result");

   // a word with a further result still pending keeps its job at the queue head
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tlast) |-> head_valid)
      else $error("job left the queue before its last result");

endmodule

`default_nettype wire

@@ hdl/dewd_front.sv @@
// Front end of the deframer: walks the event framing one accepted word per
// cycle and posts jobs to the queue. Depends on dewd_pkg.
`default_nettype none

module dewd_front
   import dewd_pkg::*;
#(
   parameter int PAYLOAD_WORDS   = 640,
   parameter int HEAD_SKIP_WORDS = 11,
   parameter int TAIL_SKIP_WORDS = 9
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                accept,
   input  wire logic [WORD_W-1:0]   word,
   input  wire logic [NUMB_W-1:0]   num_boards,
   output logic                     push,
   output job_type                  job
);

   localparam int MAX_A   = (PAYLOAD_WORDS > HEAD_SKIP_WORDS) ? PAYLOAD_WORDS : HEAD_SKIP_WORDS;
   localparam int MAX_CNT = (MAX_A > TAIL_SKIP_WORDS) ? MAX_A : TAIL_SKIP_WORDS;
   localparam int WC_W    = $clog2(MAX_CNT + 1);
   localparam int WCX_W   = WC_W + 1;

   typedef enum logic [7:0] {
      ST_EVHDR    = 8'b0000_0001,
      ST_DETHUNT  = 8'b0000_0010,
      ST_CARDHUNT = 8'b0000_0100,
      ST_HEADSKIP = 8'b0000_1000,
      ST_PAYLOAD  = 8'b0001_0000,
      ST_FOOT1    = 8'b0010_0000,
      ST_FOOT2    = 8'b0100_0000,
      ST_TAILSKIP = 8'b1000_0000
   } state_type;

   state_type           state_ff, state_in;
   logic [BOARD_W-1:0]  board_ff, board_in;
   logic [WC_W-1:0]     wc_ff, wc_in;

   logic [NUMB_W-1:0]   boards_eff;
   logic                ev_done;
   state_type           ev_next;
   logic [WCX_W-1:0]    wc_inc;
   logic [NUMB_W-1:0]   board_inc;

   always_comb begin
      boards_eff = (num_boards > NUMB_W'(MAX_BOARDS)) ? NUMB_W'(MAX_BOARDS) : num_boards;
      ev_done    = (boards_eff == '0) && (TAIL_SKIP_WORDS == 0);
      if (boards_eff != '0) begin
         ev_next = ST_DETHUNT;
      end else if (TAIL_SKIP_WORDS == 0) begin
         ev_next = ST_EVHDR;
      end else begin
         ev_next = ST_TAILSKIP;
      end
      wc_inc    = WCX_W'(wc_ff) + WCX_W'(1);
      board_inc = NUMB_W'(board_ff) + NUMB_W'(1);
   end

   always_comb begin
      state_in  = state_ff;
      board_in  = board_ff;
      wc_in     = wc_ff;
      push      = 1'b0;
      job.op    = OP_SINGLE;
      job.kind  = KIND_DONE;
      job.first = (wc_ff == '0);
      job.board = board_ff;
      job.word  = word;
      if (accept) begin
         unique case (state_ff)
            ST_EVHDR: begin
               if (word != EV_HEADER) begin
                  push     = 1'b1;
                  job.kind = KIND_MISMATCH;
               end else begin
                  board_in = '0;
                  wc_in    = '0;
                  state_in = ev_next;
                  push     = ev_done;
               end
            end
            ST_DETHUNT: begin
               if (word == DET_HEADER) begin
                  state_in = ST_CARDHUNT;
               end
            end
            ST_CARDHUNT: begin
               if ((word & CARD_MASK) == CARD_HEADER) begin
                  wc_in    = '0;
                  state_in = (HEAD_SKIP_WORDS == 0) ? ST_PAYLOAD : ST_HEADSKIP;
               end else if (word == EV_HEADER) begin
                  board_in = '0;
                  wc_in    = '0;
                  state_in = ev_next;
                  push     = 1'b1;
                  job.op   = ev_done ? OP_TRUNC_DONE : OP_SINGLE;
                  job.kind = KIND_TRUNC;
               end
            end
            ST_HEADSKIP: begin
               if (wc_inc >= WCX_W'(HEAD_SKIP_WORDS)) begin
                  wc_in    = '0;
                  state_in = ST_PAYLOAD;
               end else begin
                  wc_in = wc_inc[WC_W-1:0];
               end
            end
            ST_PAYLOAD: begin
               push   = 1'b1;
               job.op = OP_SAMPLES;
               if (wc_inc >= WCX_W'(PAYLOAD_WORDS)) begin
                  wc_in    = '0;
                  state_in = ST_FOOT1;
               end else begin
                  wc_in = wc_inc[WC_W-1:0];
               end
            end
            ST_FOOT1, ST_FOOT2: begin
               if (word == EV_HEADER) begin
                  board_in = '0;
                  wc_in    = '0;
                  state_in = ev_next;
                  push     = 1'b1;
                  job.op   = ev_done ? OP_TRUNC_DONE : OP_SINGLE;
                  job.kind = KIND_TRUNC;
               end else if (state_ff == ST_FOOT1) begin
                  state_in = ST_FOOT2;
               end else if (board_inc < boards_eff) begin
                  board_in = board_inc[BOARD_W-1:0];
                  state_in = ST_DETHUNT;
               end else begin
                  wc_in = '0;
                  if (TAIL_SKIP_WORDS == 0) begin
                     state_in = ST_EVHDR;
                     push     = 1'b1;
                  end else begin
                     state_in = ST_TAILSKIP;
                  end
               end
            end
            ST_TAILSKIP: begin
               if (wc_inc >= WCX_W'(TAIL_SKIP_WORDS)) begin
                  wc_in    = '0;
                  state_in = ST_EVHDR;
                  push     = 1'b1;
               end else begin
                  wc_in = wc_inc[WC_W-1:0];
               end
            end
            default: begin
               state_in = ST_EVHDR;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_EVHDR;
         board_ff <= '0;
         wc_ff    <= '0;
      end else begin
         state_ff <= state_in;
         board_ff <= board_in;
         wc_ff    <= wc_in;
      end
   end

endmodule

`default_nettype wire

@@ hdl/dewd_fifo.sv @@
// Short show-ahead job queue between the deframer front and back ends.
// Depends on dewd_pkg for the job type and the queue depth.
`default_nettype none

module dewd_fifo
   import dewd_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push,
   input  wire job_type  push_job,
   output logic          full,
   input  wire logic     pop,
   output job_type       head,
   output logic          head_valid
);

   job_type             slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]    wr_ff, wr_in;
   logic [PTR_W-1:0]    rd_ff, rd_in;
   logic [PTR_W:0]      cnt_ff, cnt_in;

   assign full       = (cnt_ff == (PTR_W+1)'(QUEUE_DEPTH));
   assign head_valid = (cnt_ff != '0);
   assign head       = slot_ff[rd_ff];

   always_comb begin
      wr_in  = push ? wr_ff + PTR_W'(1) : wr_ff;
      rd_in  = pop ? rd_ff + PTR_W'(1) : rd_ff;
      cnt_in = cnt_ff + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

`default_nettype wire

@@ hdl/dewd_back.sv @@
// Back end of the deframer: turns queued jobs into results, one per cycle while
// rsp_tready allows, through a registered output stage. Depends on dewd_pkg.
`default_nettype none

module dewd_back
   import dewd_pkg::*;
#(
   parameter int CHANNELS_PER_CHIP = 64,
   parameter int ADC_COUNT         = 5,
   parameter int PAYLOAD_WORDS     = 640
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire job_type                  head,
   input  wire logic                     head_valid,
   output logic                          pop,
   output logic                          rsp_tvalid,
   input  wire logic                     rsp_tready,
   output logic [RSP_TDATA_W-1:0]        rsp_tdata,
   output logic [1:0]                    rsp_tuser,
   output logic                          rsp_tlast
);

   localparam int S_W     = $clog2(2*PAYLOAD_WORDS + 1);
   localparam int R_W     = $clog2(2*ADC_COUNT + 1);
   localparam int CHX_RAW = $clog2(2*CHANNELS_PER_CHIP*ADC_COUNT + 2*PAYLOAD_WORDS + 1) + 1;
   localparam int CHX_W   = (CHX_RAW > CHAN_W) ? CHX_RAW : CHAN_W;
   localparam int PAD_W   = RSP_TDATA_W - SMP_W - CHAN_W - DET_W;

   // s = half index xor 1 kept as quotient and remainder by ADC_COUNT
   logic [R_W-1:0]     r_ff, r_in;
   logic [S_W-1:0]     q_ff, q_in;
   logic               half_ff, half_in;

   logic               valid_ff, valid_in;
   kind_type           kind_ff, kind_in;
   logic [DET_W-1:0]   det_ff, det_in;
   logic [CHAN_W-1:0]  chan_ff, chan_in;
   logic [SMP_W-1:0]   smp_ff, smp_in;
   logic               last_ff, last_in;

   logic [R_W-1:0]     eff_r, r1, rp2, sel_r;
   logic [S_W-1:0]     eff_q, q1, sel_q;
   logic [CHX_W-1:0]   chan_x;
   logic               load, done;

   always_comb begin
      eff_r = head.first ? '0 : r_ff;
      eff_q = head.first ? '0 : q_ff;
      // s of the low half is one above the pair base
      if (eff_r + R_W'(1) == R_W'(ADC_COUNT)) begin
         r1 = '0;
         q1 = eff_q + S_W'(1);
      end else begin
         r1 = eff_r + R_W'(1);
         q1 = eff_q;
      end
      // advance the pair base by two halves
      rp2 = eff_r + R_W'(2);
      if (rp2 >= R_W'(2*ADC_COUNT)) begin
         r_in = rp2 - R_W'(2*ADC_COUNT);
         q_in = eff_q + S_W'(2);
      end else if (rp2 >= R_W'(ADC_COUNT)) begin
         r_in = rp2 - R_W'(ADC_COUNT);
         q_in = eff_q + S_W'(1);
      end else begin
         r_in = rp2;
         q_in = eff_q;
      end
      sel_r  = half_ff ? eff_r : r1;
      sel_q  = half_ff ? eff_q : q1;
      chan_x = CHX_W'(sel_q >> 1) + CHX_W'(2*CHANNELS_PER_CHIP) * CHX_W'(sel_r);
   end

   always_comb begin
      load    = head_valid && (!valid_ff || rsp_tready);
      kind_in = KIND_SAMPLE;
      det_in  = '0;
      chan_in = '0;
      smp_in  = '0;
      last_in = 1'b1;
      done    = 1'b1;
      unique case (head.op)
         OP_SAMPLES: begin
            det_in  = {head.board, sel_q[0]};
            chan_in = chan_x[CHAN_W-1:0];
            smp_in  = half_ff ? head.word[31:18] : head.word[15:2];
            last_in = half_ff;
            done    = half_ff;
         end
         OP_TRUNC_DONE: begin
            kind_in = half_ff ? KIND_DONE : KIND_TRUNC;
            last_in = half_ff;
            done    = half_ff;
         end
         OP_SINGLE: begin
            kind_in = head.kind;
         end
         default: begin
            kind_in = KIND_MISMATCH;
         end
      endcase
      pop      = load && done;
      half_in  = load ? !done : half_ff;
      valid_in = load ? 1'b1 : (valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         half_ff  <= 1'b0;
         r_ff     <= '0;
         q_ff     <= '0;
      end else begin
         valid_ff <= valid_in;
         half_ff  <= half_in;
         if (pop && head.op == OP_SAMPLES) begin
            r_ff <= r_in;
            q_ff <= q_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         kind_ff <= kind_in;
         det_ff  <= det_in;
         chan_ff <= chan_in;
         smp_ff  <= smp_in;
         last_ff <= last_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {{PAD_W{1'b0}}, smp_ff, chan_ff, det_ff};
   assign rsp_tuser  = kind_ff;
   assign rsp_tlast  = last_ff;

endmodule

`default_nettype wire
